// ===== design/pop3cr_pkg.sv =====
package pop3cr_pkg;

	localparam int LINE_LEN_W = 10;
	localparam int ARG_LEN_W  = 6;
	localparam int NUM_CMDS   = 8;

	localparam int MAX_LINE_DEFAULT = 512;
	localparam int MAX_ARG_DEFAULT  = 40;

	localparam logic [3:0] CODE_USER  = 4'd0;
	localparam logic [3:0] CODE_PASS  = 4'd1;
	localparam logic [3:0] CODE_APOP  = 4'd2;
	localparam logic [3:0] CODE_LIST  = 4'd3;
	localparam logic [3:0] CODE_RETR  = 4'd4;
	localparam logic [3:0] CODE_TOP   = 4'd5;
	localparam logic [3:0] CODE_UIDL  = 4'd6;
	localparam logic [3:0] CODE_CAPA  = 4'd7;
	localparam logic [3:0] CODE_OTHER = 4'd8;

	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_SPACE = 8'h20;

	typedef logic [3:0] cmd_code_t;
	typedef logic [1:0] arg_count_t;

	// keyword letters, upper case; index [cmd][position]
	localparam logic [0:NUM_CMDS-1][0:3][7:0] KW_TEXT = '{
		'{"U", "S", "E", "R"},
		'{"P", "A", "S", "S"},
		'{"A", "P", "O", "P"},
		'{"L", "I", "S", "T"},
		'{"R", "E", "T", "R"},
		'{"T", "O", "P", 8'h00},
		'{"U", "I", "D", "L"},
		'{"C", "A", "P", "A"}
	};
	// position of the last keyword letter
	localparam logic [0:NUM_CMDS-1][1:0] KW_LAST = '{
		2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3
	};
	localparam logic [0:NUM_CMDS-1][1:0] KW_MAX = '{
		2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0
	};
	localparam logic [0:NUM_CMDS-1][1:0] KW_MIN = '{
		2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0
	};

	function automatic logic multiline_of(cmd_code_t code, arg_count_t cnt);
		logic ml;
		ml = 1'b0;
		case (code)
			CODE_LIST, CODE_UIDL: ml = (cnt == 2'd0);
			CODE_TOP:             ml = (cnt == 2'd2);
			CODE_RETR:            ml = (cnt == 2'd1);
			CODE_CAPA:            ml = 1'b1;
			default:              ml = 1'b0;
		endcase
		return ml;
	endfunction

endpackage

// ===== design/pop3_command_recognizer.sv =====
// channel | signals                               | direction
// --------+---------------------------------------+----------
// in      | in_valid, in_ready, rx_byte           | request in
// out     | out_valid, out_ready, cmd_code,       | request out
//         | arg_count, multiline_reply            |
//
// One byte per cycle while no result stalls; a line result is registered
// from its terminating LF (input register, then result register).
// Reset puts the line state in keyword phase and empties both registers.
// A stalled result holds the byte stage; the byte stage holds in_ready low
// only while it is full and cannot advance.
module pop3_command_recognizer #(
	parameter int MAX_LINE = pop3cr_pkg::MAX_LINE_DEFAULT,
	parameter int MAX_ARG  = pop3cr_pkg::MAX_ARG_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pop3cr_pkg::cmd_code_t  cmd_code,
	output pop3cr_pkg::arg_count_t arg_count,
	output logic                   multiline_reply
);
	import pop3cr_pkg::*;

	localparam logic [1:0] PH_KEY  = 2'd0;
	localparam logic [1:0] PH_ARGS = 2'd1;
	localparam logic [1:0] PH_CRLF = 2'd2;
	localparam logic [1:0] PH_ERR  = 2'd3;

	localparam logic [LINE_LEN_W-1:0] LINE_LIMIT = LINE_LEN_W'(MAX_LINE);
	localparam logic [ARG_LEN_W-1:0]  ARG_LIMIT  = ARG_LEN_W'(MAX_ARG);

	logic [7:0] rx_byte_s1;
	logic       valid_s1;
	logic       advance;

	logic [1:0]            phase_q, phase_n;
	logic [NUM_CMDS-1:0]   cand_q, cand_n;
	logic [LINE_LEN_W-1:0] line_len_q, line_len_n;
	logic [ARG_LEN_W-1:0]  arg_len_q, arg_len_n;
	arg_count_t            arg_total_q, arg_total_n;
	cmd_code_t             matched_q, matched_n;

	cmd_code_t  cmd_code_q;
	arg_count_t arg_count_q;
	logic       ml_q;
	logic       out_valid_q;

	logic [7:0]          up_c;
	logic [NUM_CMDS-1:0] hit_c, done_c;
	logic [2:0]          sel_c;
	logic [2:0]          m_c;
	arg_count_t          tot_c;
	logic                ok_c;
	logic                emit_c, emit_err_c;
	arg_count_t          emit_cnt_c;
	cmd_code_t           emit_code_c;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		phase_n     = phase_q;
		cand_n      = cand_q;
		line_len_n  = line_len_q;
		arg_len_n   = arg_len_q;
		arg_total_n = arg_total_q;
		matched_n   = matched_q;
		emit_c      = 1'b0;
		emit_err_c  = 1'b0;
		emit_cnt_c  = arg_total_q;
		up_c        = (rx_byte_s1 inside {["a":"z"]}) ? rx_byte_s1 - 8'd32 : rx_byte_s1;
		hit_c       = '0;
		done_c      = '0;
		sel_c       = '0;
		m_c         = matched_q[2:0];
		tot_c       = (arg_len_q > ARG_LEN_W'(1)) ? arg_total_q + 2'd1 : arg_total_q;
		ok_c        = (tot_c <= KW_MAX[m_c]) && (tot_c >= KW_MIN[m_c]);

		for (int i = 0; i < NUM_CMDS; i++) begin
			hit_c[i]  = cand_q[i] && (line_len_q < LINE_LEN_W'(4)) &&
				(up_c == KW_TEXT[i][line_len_q[1:0]]);
			done_c[i] = hit_c[i] && (line_len_q[1:0] == KW_LAST[i]);
		end
		for (int i = NUM_CMDS - 1; i >= 0; i--) begin
			if (done_c[i]) begin
				sel_c = 3'(i);
			end
		end

		case (phase_q)
			PH_KEY: begin
				if (rx_byte_s1 == BYTE_LF) begin
					emit_c     = 1'b1;
					emit_err_c = 1'b1;
				end else begin
					cand_n = hit_c;
					if (|done_c) begin
						matched_n = {1'b0, sel_c};
						arg_len_n = '0;
						phase_n   = (KW_MAX[sel_c] != 2'd0) ? PH_ARGS : PH_CRLF;
					end else if (hit_c == '0) begin
						phase_n = PH_ERR;
					end
				end
			end
			PH_ARGS: begin
				if (rx_byte_s1 == BYTE_SPACE) begin
					if (arg_total_q == KW_MAX[m_c]) begin
						phase_n = PH_ERR;
					end else if (arg_len_q == '0) begin
						arg_len_n = ARG_LEN_W'(1);
					end else if (arg_len_q > ARG_LEN_W'(1)) begin
						arg_total_n = arg_total_q + 2'd1;
						arg_len_n   = ARG_LEN_W'(1);
					end
				end else if (rx_byte_s1 != BYTE_CR && rx_byte_s1 != BYTE_LF) begin
					if (arg_len_q == '0) begin
						phase_n = PH_ERR;
					end else begin
						arg_len_n = arg_len_q + ARG_LEN_W'(1);
					end
				end else begin
					arg_total_n = tot_c;
					if (rx_byte_s1 == BYTE_CR) begin
						if (ok_c) begin
							phase_n   = PH_CRLF;
							arg_len_n = ARG_LEN_W'(1);
						end else begin
							phase_n = PH_ERR;
						end
					end else begin
						emit_c     = 1'b1;
						emit_err_c = !ok_c;
						emit_cnt_c = tot_c;
					end
				end
			end
			PH_CRLF: begin
				if (rx_byte_s1 == (arg_len_q[0] ? BYTE_LF : BYTE_CR)) begin
					if (arg_len_q[0]) begin
						emit_c = 1'b1;
					end else begin
						arg_len_n = ARG_LEN_W'(1);
					end
				end else begin
					phase_n = PH_ERR;
				end
			end
			default: begin
				if (rx_byte_s1 == BYTE_LF) begin
					emit_c     = 1'b1;
					emit_err_c = 1'b1;
				end
			end
		endcase

		if (emit_c) begin
			phase_n     = PH_KEY;
			cand_n      = '1;
			line_len_n  = '0;
			arg_len_n   = '0;
			arg_total_n = '0;
			matched_n   = CODE_OTHER;
		end else begin
			if (line_len_q == LINE_LIMIT ||
				(phase_n == PH_ARGS && arg_len_n == ARG_LIMIT)) begin
				phase_n = PH_ERR;
			end
			if (line_len_q != '1) begin
				line_len_n = line_len_q + LINE_LEN_W'(1);
			end
		end

		emit_code_c = (emit_err_c || matched_q > CODE_CAPA) ? CODE_OTHER : matched_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_KEY;
			cand_q      <= '1;
			line_len_q  <= '0;
			arg_len_q   <= '0;
			arg_total_q <= '0;
			matched_q   <= CODE_OTHER;
		end else if (advance) begin
			phase_q     <= phase_n;
			cand_q      <= cand_n;
			line_len_q  <= line_len_n;
			arg_len_q   <= arg_len_n;
			arg_total_q <= arg_total_n;
			matched_q   <= matched_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_c) begin
			cmd_code_q  <= emit_code_c;
			arg_count_q <= emit_cnt_c;
			ml_q        <= multiline_of(emit_code_c, emit_cnt_c);
		end
	end

	assign out_valid       = out_valid_q;
	assign cmd_code        = cmd_code_q;
	assign arg_count       = arg_count_q;
	assign multiline_reply = ml_q;

	a_other_not_multiline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_code == CODE_OTHER |-> !multiline_reply)
		else $error("multiline flag on unrecognized command");

	a_key_no_args: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_KEY |-> arg_total_q == 2'd0 && arg_len_q == '0)
		else $error("argument state left over in keyword phase");

	a_crlf_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CRLF |-> arg_len_q <= ARG_LEN_W'(1))
		else $error("line-end tracker out of range");

	a_key_has_cand: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_KEY |-> cand_q != '0)
		else $error("keyword phase with no candidate");

	a_matched_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ARGS || phase_q == PH_CRLF |-> matched_q <= CODE_CAPA)
		else $error("argument phase without a matched command");

endmodule
